// File: rtl/lia_pkg.sv
// ----------------------------------------------------------------------------
// Light intensity attenuation package
// Widths, register codes, light kinds and the CORDIC arctangent table shared
// by the attenuation pipeline and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package lia_pkg;

    // Field and datapath widths.
    localparam int COORD_W    = 16;
    localparam int OFF_W      = 17;
    localparam int SQ_W       = 32;
    localparam int PROD_W     = 33;
    localparam int DIST2_W    = 34;
    localparam int DOT_W      = 35;
    localparam int T_W        = 29;
    localparam int TA_W       = 28;
    localparam int TSQ_W      = 56;
    localparam int RAD_W      = 50;
    localparam int ROOT_W     = 25;
    localparam int XY_W       = 32;
    localparam int Z_W        = 26;
    localparam int ATAN_W     = 22;
    localparam int CORDIC_MAX = 24;
    localparam int ANGLE_W    = 16;
    localparam int QUO_W      = 16;
    localparam int SCALE_W    = 17;
    localparam int NUM_W      = 32;
    localparam int DEN_W      = 41;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [ANGLE_W-1:0] MAX_ANGLE  = 16'd46080;
    localparam logic [Z_W-1:0]     NINETY_DEG = 26'd5898240;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LIGHT_KIND,
        REG_COLOR,
        REG_POSITION,
        REG_DIRECTION,
        REG_INNER,
        REG_OUTER
    } cfg_reg_t;

    // Light kinds; the last code turns the light off.
    typedef enum logic [1:0] {
        KIND_DIRECTIONAL,
        KIND_POINT,
        KIND_SPOT,
        KIND_OFF
    } kind_t;

    // How the spot scale is formed after the angle is known.
    typedef enum logic [1:0] {
        SCALE_FULL,
        SCALE_ZERO,
        SCALE_DIV
    } scale_mode_t;

    // Rounded atan(2^-i) in degrees, Q6.16.
    localparam logic [ATAN_W-1:0] ATAN_TAB [CORDIC_MAX] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
        22'd234379,  22'd117304,  22'd58666,  22'd29335,
        22'd14668,   22'd7334,    22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,
        22'd57,      22'd29,      22'd14,     22'd7,
        22'd4,       22'd2,       22'd1,      22'd0
    };

endpackage

`default_nettype wire

// File: rtl/lia_if.sv
// ----------------------------------------------------------------------------
// Light intensity attenuation channels
// Valid/ready channels for surface points, intensity results and
// configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface lia_pt_if;
    logic                                valid;
    logic                                ready;
    logic signed [lia_pkg::COORD_W-1:0]  point_x;
    logic signed [lia_pkg::COORD_W-1:0]  point_y;
    logic signed [lia_pkg::COORD_W-1:0]  point_z;

    modport source (output valid, point_x, point_y, point_z, input ready);
    modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface lia_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
    logic        saturated;

    modport source (output valid, red_out, green_out, blue_out, saturated, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, saturated, output ready);
endinterface

interface lia_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [lia_pkg::CFG_IDX_W-1:0]      index;
    logic [lia_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/lia_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Square root cell
// Decides one bit of an integer square root and hands the partial root,
// the remainder and the side data to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module lia_sqrt_cell #(
    parameter int BIT    = 0,
    parameter int SIDE_W = 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [lia_pkg::RAD_W-1:0]     in_rem,
    input  logic [lia_pkg::ROOT_W-1:0]    in_root,
    input  logic [SIDE_W-1:0]             in_side,
    output logic                          out_valid,
    output logic [lia_pkg::RAD_W-1:0]     out_rem,
    output logic [lia_pkg::ROOT_W-1:0]    out_root,
    output logic [SIDE_W-1:0]             out_side
);
    import lia_pkg::*;

    localparam int TW = RAD_W + 2;

    logic                valid_reg;
    logic [RAD_W-1:0]    rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [SIDE_W-1:0]   side_reg;
    logic [TW-1:0]       trial;

    // (r + 2^b)^2 - r^2 = r * 2^(b+1) + 2^(2b).
    always_comb
    begin
        trial     = (TW'(in_root) << (BIT + 1)) | (TW'(1) << (2 * BIT));
        rem_next  = in_rem;
        root_next = in_root;
        if (TW'(in_rem) >= trial)
        begin
            rem_next  = in_rem - RAD_W'(trial);
            root_next = in_root | (ROOT_W'(1) << BIT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

// File: rtl/lia_cordic_cell.sv
// ----------------------------------------------------------------------------
// CORDIC vectoring cell
// Performs one vectoring rotation toward the x axis and accumulates the
// rotated angle in degrees.
// ----------------------------------------------------------------------------
`default_nettype none

module lia_cordic_cell #(
    parameter int ITER   = 0,
    parameter int SIDE_W = 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [lia_pkg::XY_W-1:0]   in_x,
    input  logic signed [lia_pkg::XY_W-1:0]   in_y,
    input  logic signed [lia_pkg::Z_W-1:0]    in_z,
    input  logic [SIDE_W-1:0]                 in_side,
    output logic                              out_valid,
    output logic signed [lia_pkg::XY_W-1:0]   out_x,
    output logic signed [lia_pkg::XY_W-1:0]   out_y,
    output logic signed [lia_pkg::Z_W-1:0]    out_z,
    output logic [SIDE_W-1:0]                 out_side
);
    import lia_pkg::*;

    logic                    valid_reg;
    logic signed [XY_W-1:0]  x_reg, x_next;
    logic signed [XY_W-1:0]  y_reg, y_next;
    logic signed [Z_W-1:0]   z_reg, z_next;
    logic [SIDE_W-1:0]       side_reg;
    logic signed [XY_W-1:0]  xs, ys;
    logic signed [Z_W-1:0]   step;

    // Rotate by the sign of y; y at zero leaves the vector as it is.
    always_comb
    begin
        xs     = in_x >>> ITER;
        ys     = in_y >>> ITER;
        step   = $signed(Z_W'(ATAN_TAB[ITER]));
        x_next = in_x;
        y_next = in_y;
        z_next = in_z;
        if (in_y > 0)
        begin
            x_next = in_x + ys;
            y_next = in_y - xs;
            z_next = in_z + step;
        end
        else if (in_y < 0)
        begin
            x_next = in_x - ys;
            y_next = in_y + xs;
            z_next = in_z - step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

// File: rtl/lia_div_cell.sv
// ----------------------------------------------------------------------------
// Restoring division cell
// Decides one quotient bit by comparing the remainder with the shifted
// divisor, and hands remainder, divisor and quotient onward.
// ----------------------------------------------------------------------------
`default_nettype none

module lia_div_cell #(
    parameter int NUM_W  = 32,
    parameter int DEN_W  = 16,
    parameter int BIT    = 0,
    parameter int SIDE_W = 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [NUM_W-1:0]              in_rem,
    input  logic [DEN_W-1:0]              in_den,
    input  logic [lia_pkg::QUO_W-1:0]     in_quo,
    input  logic [SIDE_W-1:0]             in_side,
    output logic                          out_valid,
    output logic [NUM_W-1:0]              out_rem,
    output logic [DEN_W-1:0]              out_den,
    output logic [lia_pkg::QUO_W-1:0]     out_quo,
    output logic [SIDE_W-1:0]             out_side
);
    import lia_pkg::*;

    localparam int CMP_W = ((NUM_W > DEN_W + BIT) ? NUM_W : DEN_W + BIT) + 1;

    logic               valid_reg;
    logic [NUM_W-1:0]   rem_reg, rem_next;
    logic [DEN_W-1:0]   den_reg;
    logic [QUO_W-1:0]   quo_reg, quo_next;
    logic [SIDE_W-1:0]  side_reg;
    logic [CMP_W-1:0]   shifted;

    // Subtract the divisor at this bit weight when it fits.
    always_comb
    begin
        shifted  = CMP_W'(in_den) << BIT;
        rem_next = in_rem;
        quo_next = in_quo;
        if (CMP_W'(in_rem) >= shifted)
        begin
            rem_next = in_rem - NUM_W'(shifted);
            quo_next = in_quo | (QUO_W'(1) << BIT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            den_reg  <= in_den;
            quo_reg  <= quo_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_den   = den_reg;
    assign out_quo   = quo_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

// File: rtl/light_intensity_attenuation.sv
// ----------------------------------------------------------------------------
// Light intensity attenuation
// RGB intensity of a directional, point or spot light at a surface point.
// ----------------------------------------------------------------------------
// The block takes one surface point per clock while the chain is not halted
// and returns its intensity from the end of the cell chain: a 25-cell square
// root, one CORDIC cell per iteration, a 16-cell divider for the spot falloff
// and three 16-cell divider lanes for the distance attenuation. The whole
// chain moves forward together; an output register with a skid stage lets a
// new point enter while a result waits, and the chain halts only when both
// are full. The user must write configuration through its own port only
// while the block holds no point; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module light_intensity_attenuation #(
    parameter int ANGLE_ITERATIONS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    lia_cfg_if.sink   cfg,
    lia_pt_if.sink    pt,
    lia_res_if.source res
);
    import lia_pkg::*;

    localparam int CORDIC_N =
        (ANGLE_ITERATIONS < CORDIC_MAX) ? ANGLE_ITERATIONS : CORDIC_MAX;
    localparam int SIDE1_W  = T_W + DIST2_W;
    localparam int SIDE2_W  = 2 + DIST2_W;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic        sat;
    } result_t;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    kind_t                  kind_reg;
    logic [CFG_DATA_W-1:0]  color_reg;
    logic [CFG_DATA_W-1:0]  position_reg;
    logic [CFG_DATA_W-1:0]  direction_reg;
    logic [ANGLE_W-1:0]     inner_reg;
    logic [ANGLE_W-1:0]     outer_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg      <= KIND_POINT;
            color_reg     <= '0;
            position_reg  <= '0;
            direction_reg <= '0;
            inner_reg     <= '0;
            outer_reg     <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_LIGHT_KIND: kind_reg      <= kind_t'(cfg.data[1:0]);
                REG_COLOR:      color_reg     <= cfg.data;
                REG_POSITION:   position_reg  <= cfg.data;
                REG_DIRECTION:  direction_reg <= cfg.data;
                REG_INNER:      inner_reg     <= cfg.data[ANGLE_W-1:0];
                REG_OUTER:      outer_reg     <= cfg.data[ANGLE_W-1:0];
                default:        ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Chain advance: everything moves unless the skid stage is occupied.
    // ------------------------------------------------------------------
    logic adv;
    logic skid_full_reg;
    logic out_valid_reg;

    assign adv      = !skid_full_reg;
    assign pt.ready = adv;

    // ------------------------------------------------------------------
    // Offset from the light, then squares and axis products.
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0]   pt_coord [3];
    logic signed [OFF_W-1:0]     off_next [3];
    logic signed [OFF_W-1:0]     off_reg  [3];
    logic signed [2*OFF_W-1:0]   sq_wide  [3];
    logic [SQ_W-1:0]             sq_next  [3];
    logic [SQ_W-1:0]             sq_reg   [3];
    logic signed [PROD_W-1:0]    prod_next [3];
    logic signed [PROD_W-1:0]    prod_reg  [3];
    logic                        s1_valid_reg, s2_valid_reg;

    assign pt_coord[0] = pt.point_x;
    assign pt_coord[1] = pt.point_y;
    assign pt_coord[2] = pt.point_z;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            off_next[k]  = OFF_W'(pt_coord[k])
                         - OFF_W'($signed(position_reg[(2-k)*COORD_W +: COORD_W]));
            sq_wide[k]   = (2*OFF_W)'(off_reg[k]) * (2*OFF_W)'(off_reg[k]);
            sq_next[k]   = sq_wide[k][SQ_W-1:0];
            prod_next[k] = PROD_W'(off_reg[k])
                         * PROD_W'($signed(direction_reg[(2-k)*COORD_W +: COORD_W]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                off_reg[k]  <= off_next[k];
                sq_reg[k]   <= sq_next[k];
                prod_reg[k] <= prod_next[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Squared distance and projection on the axis.
    // ------------------------------------------------------------------
    logic [DIST2_W-1:0]        dist2_next, s3_dist2_reg, s4_dist2_reg, s5_dist2_reg;
    logic signed [DOT_W-1:0]   dot_sum;
    logic signed [T_W-1:0]     s3_t_reg, s4_t_reg, s5_t_reg;
    logic                      s3_valid_reg, s4_valid_reg, s5_valid_reg;

    always_comb
    begin
        dist2_next = DIST2_W'(sq_reg[0]) + DIST2_W'(sq_reg[1]) + DIST2_W'(sq_reg[2]);
        dot_sum    = DOT_W'(prod_reg[0]) + DOT_W'(prod_reg[1]) + DOT_W'(prod_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_dist2_reg <= dist2_next;
            s3_t_reg     <= dot_sum[DOT_W-1:6];
        end
    end

    // Squared projection.
    logic [T_W-1:0]     t_abs;
    logic [TSQ_W-1:0]   tsq_next, s4_tsq_reg;

    always_comb
    begin
        t_abs    = s3_t_reg[T_W-1] ? T_W'(-s3_t_reg) : T_W'(s3_t_reg);
        tsq_next = TSQ_W'(t_abs[TA_W-1:0]) * TSQ_W'(t_abs[TA_W-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_tsq_reg   <= tsq_next;
            s4_t_reg     <= s3_t_reg;
            s4_dist2_reg <= s3_dist2_reg;
        end
    end

    // Radicand for the perpendicular length, floored at zero.
    logic [RAD_W-1:0]   m2;
    logic [RAD_W-1:0]   rad_next, s5_rad_reg;

    always_comb
    begin
        m2 = {s4_dist2_reg, 16'b0};
        if (TSQ_W'(m2) > s4_tsq_reg)
        begin
            rad_next = m2 - s4_tsq_reg[RAD_W-1:0];
        end
        else
        begin
            rad_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_rad_reg   <= rad_next;
            s5_t_reg     <= s4_t_reg;
            s5_dist2_reg <= s4_dist2_reg;
        end
    end

    // Valid bits of the front stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= pt.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Square root chain, one root bit per cell.
    // ------------------------------------------------------------------
    logic                 sr_valid [ROOT_W+1];
    logic [RAD_W-1:0]     sr_rem   [ROOT_W+1];
    logic [ROOT_W-1:0]    sr_root  [ROOT_W+1];
    logic [SIDE1_W-1:0]   sr_side  [ROOT_W+1];

    assign sr_valid[0] = s5_valid_reg;
    assign sr_rem[0]   = s5_rad_reg;
    assign sr_root[0]  = '0;
    assign sr_side[0]  = {s5_t_reg, s5_dist2_reg};

    for (genvar g = 0; g < ROOT_W; g++)
    begin : g_sqrt
        lia_sqrt_cell #(
            .BIT    (ROOT_W - 1 - g),
            .SIDE_W (SIDE1_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (sr_valid[g]),
            .in_rem    (sr_rem[g]),
            .in_root   (sr_root[g]),
            .in_side   (sr_side[g]),
            .out_valid (sr_valid[g+1]),
            .out_rem   (sr_rem[g+1]),
            .out_root  (sr_root[g+1]),
            .out_side  (sr_side[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Fold a negative projection into the first quadrant.
    // ------------------------------------------------------------------
    logic signed [T_W-1:0]    sr_t;
    logic signed [XY_W-1:0]   pre_x_next, pre_y_next;
    logic signed [Z_W-1:0]    pre_z_next;
    logic                     pre_valid_reg;
    logic signed [XY_W-1:0]   pre_x_reg, pre_y_reg;
    logic signed [Z_W-1:0]    pre_z_reg;
    logic [DIST2_W-1:0]       pre_dist2_reg;

    always_comb
    begin
        sr_t = sr_side[ROOT_W][SIDE1_W-1:DIST2_W];
        if (sr_t < 0)
        begin
            pre_x_next = XY_W'(sr_root[ROOT_W]);
            pre_y_next = -XY_W'(sr_t);
            pre_z_next = $signed(NINETY_DEG);
        end
        else
        begin
            pre_x_next = XY_W'(sr_t);
            pre_y_next = XY_W'(sr_root[ROOT_W]);
            pre_z_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pre_x_reg     <= pre_x_next;
            pre_y_reg     <= pre_y_next;
            pre_z_reg     <= pre_z_next;
            pre_dist2_reg <= sr_side[ROOT_W][DIST2_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // CORDIC chain, one iteration per cell.
    // ------------------------------------------------------------------
    logic                     cr_valid [CORDIC_N+1];
    logic signed [XY_W-1:0]   cr_x     [CORDIC_N+1];
    logic signed [XY_W-1:0]   cr_y     [CORDIC_N+1];
    logic signed [Z_W-1:0]    cr_z     [CORDIC_N+1];
    logic [DIST2_W-1:0]       cr_side  [CORDIC_N+1];

    assign cr_valid[0] = pre_valid_reg;
    assign cr_x[0]     = pre_x_reg;
    assign cr_y[0]     = pre_y_reg;
    assign cr_z[0]     = pre_z_reg;
    assign cr_side[0]  = pre_dist2_reg;

    for (genvar g = 0; g < CORDIC_N; g++)
    begin : g_cordic
        lia_cordic_cell #(
            .ITER   (g),
            .SIDE_W (DIST2_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (cr_valid[g]),
            .in_x      (cr_x[g]),
            .in_y      (cr_y[g]),
            .in_z      (cr_z[g]),
            .in_side   (cr_side[g]),
            .out_valid (cr_valid[g+1]),
            .out_x     (cr_x[g+1]),
            .out_y     (cr_y[g+1]),
            .out_z     (cr_z[g+1]),
            .out_side  (cr_side[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Round the angle, clamp it and choose the falloff case.
    // ------------------------------------------------------------------
    logic signed [Z_W:0]      z_round;
    logic signed [Z_W-8:0]    z_deg;
    logic [ANGLE_W-1:0]       ang;
    scale_mode_t              mode_next;
    logic                     ang_valid_reg;
    logic [NUM_W-1:0]         ang_num_reg;
    logic [ANGLE_W-1:0]       ang_den_reg;
    logic [SIDE2_W-1:0]       ang_side_reg;

    always_comb
    begin
        z_round = (Z_W+1)'(cr_z[CORDIC_N]) + (Z_W+1)'(128);
        z_deg   = z_round[Z_W:8];
        if (z_deg < 0)
        begin
            ang = '0;
        end
        else if (z_deg > $signed((Z_W-7)'(MAX_ANGLE)))
        begin
            ang = MAX_ANGLE;
        end
        else
        begin
            ang = z_deg[ANGLE_W-1:0];
        end

        // Equal to the inner angle at a nonzero width is a full scale.
        if (kind_reg != KIND_SPOT || ang < inner_reg)
        begin
            mode_next = SCALE_FULL;
        end
        else if (ang < outer_reg)
        begin
            mode_next = (ang == inner_reg) ? SCALE_FULL : SCALE_DIV;
        end
        else
        begin
            mode_next = SCALE_ZERO;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ang_num_reg  <= {outer_reg - ang, 16'b0};
            ang_den_reg  <= outer_reg - inner_reg;
            ang_side_reg <= {mode_next, cr_side[CORDIC_N]};
        end
    end

    // ------------------------------------------------------------------
    // Falloff divider chain.
    // ------------------------------------------------------------------
    logic                  dv_valid [QUO_W+1];
    logic [NUM_W-1:0]      dv_rem   [QUO_W+1];
    logic [ANGLE_W-1:0]    dv_den   [QUO_W+1];
    logic [QUO_W-1:0]      dv_quo   [QUO_W+1];
    logic [SIDE2_W-1:0]    dv_side  [QUO_W+1];

    assign dv_valid[0] = ang_valid_reg;
    assign dv_rem[0]   = ang_num_reg;
    assign dv_den[0]   = ang_den_reg;
    assign dv_quo[0]   = '0;
    assign dv_side[0]  = ang_side_reg;

    for (genvar g = 0; g < QUO_W; g++)
    begin : g_falloff
        lia_div_cell #(
            .NUM_W  (NUM_W),
            .DEN_W  (ANGLE_W),
            .BIT    (QUO_W - 1 - g),
            .SIDE_W (SIDE2_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (dv_valid[g]),
            .in_rem    (dv_rem[g]),
            .in_den    (dv_den[g]),
            .in_quo    (dv_quo[g]),
            .in_side   (dv_side[g]),
            .out_valid (dv_valid[g+1]),
            .out_rem   (dv_rem[g+1]),
            .out_den   (dv_den[g+1]),
            .out_quo   (dv_quo[g+1]),
            .out_side  (dv_side[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Scale, scaled color and the clip test.
    // ------------------------------------------------------------------
    scale_mode_t           dv_mode;
    logic [SCALE_W-1:0]    scale_next, sc_scale_reg;
    logic [DIST2_W-1:0]    sc_dist2_reg, nm_dist2_reg;
    logic                  sc_valid_reg, nm_valid_reg, ov_valid_reg;
    logic [NUM_W-1:0]      num_next [3];
    logic [NUM_W-1:0]      nm_num_reg [3];
    logic [NUM_W-1:0]      ov_num_reg [3];
    logic [DEN_W-1:0]      ov_den_reg;
    logic [2:0]            over_next, ov_over_reg;

    always_comb
    begin
        dv_mode = scale_mode_t'(dv_side[QUO_W][SIDE2_W-1:DIST2_W]);
        case (dv_mode)
            SCALE_FULL: scale_next = SCALE_W'(1) << QUO_W;
            SCALE_DIV:  scale_next = SCALE_W'(dv_quo[QUO_W]);
            default:    scale_next = '0;
        endcase
        for (int k = 0; k < 3; k++)
        begin
            num_next[k]  = NUM_W'((SCALE_W+16)'(color_reg[(2-k)*16 +: 16])
                                  * (SCALE_W+16)'(sc_scale_reg));
            over_next[k] = (DEN_W+16)'(nm_num_reg[k]) >= {nm_dist2_reg, 23'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sc_scale_reg <= scale_next;
            sc_dist2_reg <= dv_side[QUO_W][DIST2_W-1:0];
            nm_dist2_reg <= sc_dist2_reg;
            ov_den_reg   <= {nm_dist2_reg, 7'b0};
            ov_over_reg  <= over_next;
            for (int k = 0; k < 3; k++)
            begin
                nm_num_reg[k] <= num_next[k];
                ov_num_reg[k] <= nm_num_reg[k];
            end
        end
    end

    // Valid bits of the middle stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_valid_reg <= 1'b0;
            ang_valid_reg <= 1'b0;
            sc_valid_reg  <= 1'b0;
            nm_valid_reg  <= 1'b0;
            ov_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            pre_valid_reg <= sr_valid[ROOT_W];
            ang_valid_reg <= cr_valid[CORDIC_N];
            sc_valid_reg  <= dv_valid[QUO_W];
            nm_valid_reg  <= sc_valid_reg;
            ov_valid_reg  <= nm_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Attenuation divider lanes, one per color channel.
    // ------------------------------------------------------------------
    logic                ln_valid [3][QUO_W+1];
    logic [NUM_W-1:0]    ln_rem   [3][QUO_W+1];
    logic [DEN_W-1:0]    ln_den   [3][QUO_W+1];
    logic [QUO_W-1:0]    ln_quo   [3][QUO_W+1];
    logic                ln_side  [3][QUO_W+1];

    for (genvar c = 0; c < 3; c++)
    begin : g_lane
        assign ln_valid[c][0] = ov_valid_reg;
        assign ln_rem[c][0]   = ov_num_reg[c];
        assign ln_den[c][0]   = ov_den_reg;
        assign ln_quo[c][0]   = '0;
        assign ln_side[c][0]  = ov_over_reg[c];

        for (genvar g = 0; g < QUO_W; g++)
        begin : g_step
            lia_div_cell #(
                .NUM_W  (NUM_W),
                .DEN_W  (DEN_W),
                .BIT    (QUO_W - 1 - g),
                .SIDE_W (1)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (adv),
                .in_valid  (ln_valid[c][g]),
                .in_rem    (ln_rem[c][g]),
                .in_den    (ln_den[c][g]),
                .in_quo    (ln_quo[c][g]),
                .in_side   (ln_side[c][g]),
                .out_valid (ln_valid[c][g+1]),
                .out_rem   (ln_rem[c][g+1]),
                .out_den   (ln_den[c][g+1]),
                .out_quo   (ln_quo[c][g+1]),
                .out_side  (ln_side[c][g+1])
            );
        end
    end

    // ------------------------------------------------------------------
    // Final result by light kind.
    // ------------------------------------------------------------------
    logic            fin_valid;
    logic [15:0]     fin_chan [3];
    logic            fin_sat;
    result_t         fin;

    assign fin_valid = ln_valid[0][QUO_W];

    always_comb
    begin
        fin_sat = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            case (kind_reg)
                KIND_DIRECTIONAL:
                begin
                    fin_chan[k] = 16'(color_reg[(2-k)*16 +: 16] >> 7);
                end
                KIND_POINT, KIND_SPOT:
                begin
                    if (ln_side[k][QUO_W])
                    begin
                        fin_chan[k] = 16'hFFFF;
                        fin_sat     = 1'b1;
                    end
                    else
                    begin
                        fin_chan[k] = ln_quo[k][QUO_W];
                    end
                end
                default:
                begin
                    fin_chan[k] = '0;
                end
            endcase
        end
        fin.red   = fin_chan[0];
        fin.green = fin_chan[1];
        fin.blue  = fin_chan[2];
        fin.sat   = fin_sat;
    end

    // ------------------------------------------------------------------
    // Output register with skid stage.
    // ------------------------------------------------------------------
    result_t out_data_reg, skid_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else if (skid_full_reg)
        begin
            if (res.ready)
            begin
                skid_full_reg <= 1'b0;
            end
        end
        else if (fin_valid)
        begin
            if (!out_valid_reg || res.ready)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_full_reg <= 1'b1;
            end
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_full_reg)
        begin
            if (res.ready)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (fin_valid)
        begin
            if (!out_valid_reg || res.ready)
            begin
                out_data_reg <= fin;
            end
            else
            begin
                skid_data_reg <= fin;
            end
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.red_out   = out_data_reg.red;
    assign res.green_out = out_data_reg.green;
    assign res.blue_out  = out_data_reg.blue;
    assign res.saturated = out_data_reg.sat;

`ifndef SYNTHESIS
    // The skid stage holds an item only behind a waiting output.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |-> out_valid_reg)
        else $error("skid stage full while output register is empty");

    // The skid stage fills only when the output was stalled.
    a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_full_reg) |-> $past(out_valid_reg && !res.ready))
        else $error("skid stage filled without an output stall");

    // Saturation only comes from a point or spot light.
    a_sat_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.saturated) |-> (kind_reg == KIND_POINT || kind_reg == KIND_SPOT))
        else $error("saturated flag for a light without attenuation");

    // A saturated item has at least one clipped channel.
    a_sat_clipped: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.saturated) |-> (res.red_out == 16'hFFFF
            || res.green_out == 16'hFFFF || res.blue_out == 16'hFFFF))
        else $error("saturated flag without a clipped channel");
`endif

endmodule

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Light intensity attenuation testbench
// Drives surface points through the attenuation block under several light
// setups and checks each intensity against an in-bench fixed-point model of
// the directional, point and spot light falloff.
// ----------------------------------------------------------------------------

module tb;
    import lia_pkg::*;

    localparam int ITERS      = 16;
    localparam int SETTLE_CYC = 120;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } point_t;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic        sat;
    } intensity_t;

    logic clk = 1'b0;
    logic rst_n;

    lia_cfg_if cfg_ch ();
    lia_pt_if  pt_ch ();
    lia_res_if res_ch ();

    light_intensity_attenuation #(.ANGLE_ITERATIONS(ITERS)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch.sink),
        .pt    (pt_ch.sink),
        .res   (res_ch.source)
    );

    // Register copies for the predictor.
    kind_t       light_kind_r;
    logic [47:0] color_r;
    logic [47:0] position_r;
    logic [47:0] axis_r;
    logic [15:0] inner_r;
    logic [15:0] outer_r;

    intensity_t intensity_q[$];
    int         mismatches;
    bit         idling_on;
    bit         hold_pending;
    int         hold_cnt;

    always #2 clk = ~clk;

    // Integer square root, floor.
    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned trial;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = r | (64'd1 << b);
            if (trial * trial <= v)
                r = trial;
        end
        return r;
    endfunction

    // Angle of (x, y) in degrees Q8.8 by CORDIC vectoring, y not negative.
    function automatic longint unsigned cone_angle(longint x, longint y);
        longint z;
        longint xs;
        longint ys;
        longint tmp;
        z = 0;
        if (x < 0) begin
            tmp = x;
            x = y;
            y = -tmp;
            z = NINETY_DEG;
        end
        for (int i = 0; i < ITERS && i < CORDIC_MAX; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x += ys;
                y -= xs;
                z += ATAN_TAB[i];
            end
            else if (y < 0) begin
                x -= ys;
                y += xs;
                z -= ATAN_TAB[i];
            end
        end
        z = (z + 128) >>> 8;
        if (z < 0)
            z = 0;
        if (z > MAX_ANGLE)
            z = MAX_ANGLE;
        return longint'(z);
    endfunction

    // Intensity that the current light gives at one surface point.
    function automatic intensity_t predict_intensity(point_t p);
        logic [47:0]     pv;
        longint          off [3];
        longint          axv [3];
        longint unsigned col [3];
        longint unsigned chan [3];
        longint unsigned dist2;
        longint unsigned scale;
        longint unsigned q;
        longint unsigned m2;
        longint unsigned t2;
        longint unsigned ang;
        longint          dot;
        longint          t;
        longint          ta;
        logic            sat;
        intensity_t      r;
        pv = p;
        dist2 = 0;
        dot = 0;
        scale = 65536;
        sat = 1'b0;
        for (int k = 0; k < 3; k++) begin
            col[k] = color_r[32-16*k +: 16];
            axv[k] = longint'($signed(axis_r[32-16*k +: 16]));
            off[k] = longint'($signed(pv[32-16*k +: 16]))
                   - longint'($signed(position_r[32-16*k +: 16]));
            dist2 += longint'(off[k] * off[k]);
            dot += off[k] * axv[k];
            chan[k] = 0;
        end
        case (light_kind_r)
            KIND_DIRECTIONAL:
                for (int k = 0; k < 3; k++)
                    chan[k] = col[k] >> 7;
            KIND_POINT, KIND_SPOT:
                if (dist2 == 0) begin
                    for (int k = 0; k < 3; k++)
                        chan[k] = 16'hFFFF;
                    sat = 1'b1;
                end
                else begin
                    if (light_kind_r == KIND_SPOT) begin
                        t = dot >>> 6;
                        ta = (t < 0) ? -t : t;
                        m2 = dist2 << 16;
                        t2 = longint'(ta * ta);
                        ang = cone_angle(t, longint'(root_floor(m2 > t2 ? m2 - t2 : 0)));
                        if (ang < inner_r)
                            scale = 65536;
                        else if (ang < outer_r)
                            scale = ((outer_r - ang) << 16) / (outer_r - inner_r);
                        else
                            scale = 0;
                    end
                    for (int k = 0; k < 3; k++) begin
                        q = (col[k] * scale) / (dist2 << 7);
                        if (q > 16'hFFFF) begin
                            q = 16'hFFFF;
                            sat = 1'b1;
                        end
                        chan[k] = q;
                    end
                end
            default: ;
        endcase
        r.red   = chan[0][15:0];
        r.green = chan[1][15:0];
        r.blue  = chan[2][15:0];
        r.sat   = sat;
        return r;
    endfunction

    // Result side: random or held-off ready, and the check of each item.
    always @(posedge clk) begin
        intensity_t got;
        intensity_t want;
        if (res_ch.valid && res_ch.ready) begin
            got = {res_ch.red_out, res_ch.green_out, res_ch.blue_out, res_ch.saturated};
            if (intensity_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected item: %h", got);
            end
            else begin
                want = intensity_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected r=%h g=%h b=%h s=%b, got r=%h g=%h b=%h s=%b",
                                 want.red, want.green, want.blue, want.sat,
                                 got.red, got.green, got.blue, got.sat);
                end
            end
        end
        if (hold_pending) begin
            hold_pending = 1'b0;
            hold_cnt = 400;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            res_ch.ready <= 1'b0;
        end
        else
            res_ch.ready <= !(idling_on && $urandom_range(99) < 12);
    end

    // Send one point and record its expected intensity when accepted.
    task automatic send_point(point_t p);
        while (idling_on && $urandom_range(99) < 12) begin
            pt_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pt_ch.valid   <= 1'b1;
        pt_ch.point_x <= p.x;
        pt_ch.point_y <= p.y;
        pt_ch.point_z <= p.z;
        @(posedge clk);
        while (!pt_ch.ready)
            @(posedge clk);
        intensity_q.push_back(predict_intensity(p));
    endtask

    // Stop offering points and wait until every result is back.
    task automatic drain;
        pt_ch.valid <= 1'b0;
        @(posedge clk);
        while (intensity_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [47:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            REG_LIGHT_KIND: light_kind_r = kind_t'(value[1:0]);
            REG_COLOR:      color_r = value;
            REG_POSITION:   position_r = value;
            REG_DIRECTION:  axis_r = value;
            REG_INNER:      inner_r = value[15:0];
            REG_OUTER:      outer_r = value[15:0];
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [47:0] rand48();
        return {$urandom, $urandom};
    endfunction

    // Mostly a point near the light, sometimes anywhere.
    function automatic point_t near_point();
        point_t p;
        if ($urandom_range(3) == 0)
            p = rand48();
        else begin
            p.x = $signed(position_r[47:32]) + $signed(16'($urandom_range(4095) - 2048));
            p.y = $signed(position_r[31:16]) + $signed(16'($urandom_range(4095) - 2048));
            p.z = $signed(position_r[15:0])  + $signed(16'($urandom_range(4095) - 2048));
        end
        return p;
    endfunction

    // Unit axes mostly, sometimes one of arbitrary length.
    function automatic logic [47:0] pick_axis();
        case ($urandom_range(7))
            0: return {16'sd16384, 16'sd0, 16'sd0};
            1: return {16'sd0, -16'sd16384, 16'sd0};
            2: return {16'sd0, 16'sd0, 16'sd16384};
            3: return {16'sd11585, 16'sd0, -16'sd11585};
            4: return {16'sd9459, 16'sd9459, 16'sd9459};
            5: return {-16'sd9459, 16'sd9459, -16'sd9459};
            6: return rand48();
            default: return 48'd0;
        endcase
    endfunction

    task automatic test_directional;
        write_reg(REG_LIGHT_KIND, KIND_DIRECTIONAL);
        write_reg(REG_COLOR, 48'hFFFF_FFFF_FFFF);
        send_point('0);
        send_point({16'h7FFF, 16'h8000, 16'hFFFF});
        drain();
        write_reg(REG_COLOR, 48'h8000_0001_0000);
        send_point({16'h8000, 16'h7FFF, 16'h0000});
        drain();
    endtask

    task automatic test_point_light;
        write_reg(REG_LIGHT_KIND, KIND_POINT);
        write_reg(REG_POSITION, {16'sd256, -16'sd512, 16'sd0});
        write_reg(REG_COLOR, 48'h7FFF_4000_FFFF);
        // Zero distance, then 256 units away, then the far corners, then one unit away.
        send_point({16'sd256, -16'sd512, 16'sd0});
        send_point({16'sd512, -16'sd512, 16'sd0});
        send_point({16'h8000, 16'h8000, 16'h8000});
        send_point({16'h7FFF, 16'h7FFF, 16'h7FFF});
        send_point({16'sd257, -16'sd512, 16'sd0});
        drain();
    endtask

    task automatic test_spot_light;
        write_reg(REG_LIGHT_KIND, KIND_SPOT);
        write_reg(REG_POSITION, 48'd0);
        write_reg(REG_COLOR, 48'hFFFF_FFFF_FFFF);
        write_reg(REG_DIRECTION, {16'sd0, 16'sd0, 16'sd16384});
        write_reg(REG_INNER, 16'd2560);
        write_reg(REG_OUTER, 16'd7680);
        // On the axis, inside the falloff, beyond it, sideways, behind and at the light.
        send_point({16'sd0, 16'sd0, 16'sd2560});
        send_point({16'sd512, 16'sd0, 16'sd2560});
        send_point({16'sd2560, 16'sd0, 16'sd2560});
        send_point({16'sd2560, 16'sd0, 16'sd0});
        send_point({16'sd0, 16'sd0, -16'sd2560});
        send_point('0);
        drain();
        // Equal cone angles, then the widest settings.
        write_reg(REG_OUTER, 16'd2560);
        send_point({16'sd512, 16'sd0, 16'sd2560});
        send_point({16'sd0, 16'sd0, 16'sd2560});
        drain();
        write_reg(REG_INNER, 16'd0);
        write_reg(REG_OUTER, MAX_ANGLE);
        send_point({16'sd0, 16'sd0, -16'sd2560});
        send_point({16'sd100, 16'sd0, 16'sd2560});
        drain();
        // Axis longer than unit length.
        write_reg(REG_DIRECTION, {16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
        write_reg(REG_INNER, 16'd256);
        send_point({16'sd256, 16'sd256, 16'sd256});
        send_point({-16'sd256, -16'sd256, -16'sd256});
        drain();
    endtask

    task automatic test_light_off;
        write_reg(REG_LIGHT_KIND, KIND_OFF);
        send_point({16'sd3, 16'sd4, 16'sd5});
        send_point('0);
        drain();
    endtask

    // Random light setups, each followed by a batch of random points.
    task automatic test_random_lights(int phases, int per_phase);
        logic [15:0] a;
        logic [15:0] b;
        int          pick;
        for (int ph = 0; ph < phases; ph++) begin
            pick = $urandom_range(99);
            write_reg(REG_LIGHT_KIND, pick < 60 ? KIND_SPOT : pick < 85 ? KIND_POINT :
                                      pick < 95 ? KIND_DIRECTIONAL : KIND_OFF);
            write_reg(REG_COLOR, rand48());
            write_reg(REG_POSITION, $urandom_range(3) == 0 ? rand48() :
                {16'($urandom_range(8191) - 4096), 16'($urandom_range(8191) - 4096),
                 16'($urandom_range(8191) - 4096)});
            write_reg(REG_DIRECTION, pick_axis());
            a = $urandom_range(46080);
            b = $urandom_range(46080);
            case ($urandom_range(4))
                0: b = a;
                1: ;
                default: if (a > b) {a, b} = {b, a};
            endcase
            write_reg(REG_INNER, a);
            write_reg(REG_OUTER, b);
            for (int n = 0; n < per_phase; n++)
                send_point(near_point());
            drain();
        end
    endtask

    // Result side held off while points keep coming, so the pipeline fills.
    task automatic test_backpressure;
        hold_pending = 1'b1;
        for (int n = 0; n < 150; n++)
            send_point(near_point());
        drain();
    endtask

    initial begin
        mismatches   = 0;
        hold_pending = 1'b0;
        hold_cnt     = 0;
        idling_on    = 1'b1;
        light_kind_r = KIND_POINT;
        color_r      = '0;
        position_r   = '0;
        axis_r       = '0;
        inner_r      = '0;
        outer_r      = '0;
        rst_n        <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= '0;
        cfg_ch.data  <= '0;
        pt_ch.valid  <= 1'b0;
        pt_ch.point_x <= '0;
        pt_ch.point_y <= '0;
        pt_ch.point_z <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_point_light();
        test_directional();
        test_spot_light();
        test_light_off();
        test_backpressure();
        test_random_lights(10, 100);
        // A stretch with no idling on either side.
        idling_on = 1'b0;
        test_random_lights(2, 100);
        idling_on = 1'b1;
        test_random_lights(1, 50);

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Run limit.
    initial begin
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
